### design/battery_backup_mode_controller_defines.svh
// assertion macros for the battery backup mode controller checker
// expects signals clk and rst_n in the scope where a macro is used
`ifndef BATTERY_BACKUP_MODE_CONTROLLER_DEFINES_SVH
`define BATTERY_BACKUP_MODE_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BBMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BBMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/bbmc_pkg.sv
// shared types and constants for the battery backup mode controller
// no dependencies
`timescale 1ns / 1ps

package bbmc_pkg;

    // widths
    localparam int TIME_BITS   = 32;
    localparam int CHARGE_W    = 10;
    localparam int PCT_W       = 7;
    localparam int TENTHS_W    = 11;
    localparam int WATTS_W     = 16;
    localparam int POLICY_W    = 2;
    localparam int MODE_W      = 2;
    localparam int WANT_W      = 2;
    localparam int DSTATE_W    = 2;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 5;
    localparam int REG_IDX_W   = 3;

    // operation codes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // charge modes
    localparam logic [MODE_W-1:0] MODE_FLOAT       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHARGING    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DISCHARGING = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BACKUP      = 2'd3;

    // wanted supply codes
    localparam logic [WANT_W-1:0] WANT_UNCHANGED = 2'd0;
    localparam logic [WANT_W-1:0] WANT_GRID      = 2'd1;
    localparam logic [WANT_W-1:0] WANT_BATTERY   = 2'd2;
    localparam logic [WANT_W-1:0] WANT_OFFLOAD   = 2'd3;

    // direct meter state codes
    localparam logic [DSTATE_W-1:0] DSTATE_CHARGING    = 2'd1;
    localparam logic [DSTATE_W-1:0] DSTATE_DISCHARGING = 2'd2;

    // supply policy codes
    localparam logic [POLICY_W-1:0] POLICY_GRID    = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BATTERY = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_OFFLOAD = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_BACKUP_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BACKUP_HIGH  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_GRID     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFLOAD_LIM  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFFLOAD_LOW  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFFLOAD_HIGH = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_POLICY       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COOLDOWN     = 3'd7;

    // register reset values
    localparam logic [PCT_W-1:0]     RST_BACKUP_LOW   = 7'd30;
    localparam logic [PCT_W-1:0]     RST_BACKUP_HIGH  = 7'd50;
    localparam logic [TIME_BITS-1:0] RST_MIN_GRID     = TIME_BITS'(7200);
    localparam logic [WATTS_W-1:0]   RST_OFFLOAD_LIM  = 16'd0;
    localparam logic [PCT_W-1:0]     RST_OFFLOAD_LOW  = 7'd0;
    localparam logic [PCT_W-1:0]     RST_OFFLOAD_HIGH = 7'd100;
    localparam logic [POLICY_W-1:0]  RST_POLICY       = POLICY_BATTERY;
    localparam logic [TIME_BITS-1:0] RST_COOLDOWN     = '0;

    // one input word as held in the input register
    typedef struct packed {
        logic                  operation;
        logic [TIME_BITS-1:0]  now_seconds;
        logic [CHARGE_W-1:0]   charge_tenths;
        logic                  direct_state_valid;
        logic [DSTATE_W-1:0]   direct_state;
        logic                  charging_flag;
        logic                  grid_offline;
        logic                  manual_mode;
        logic                  control_present;
        logic [TIME_BITS-1:0]  last_on_seconds;
    } item_t;

    // percent to tenths of a percent: p*8 + p*2
    function automatic logic [TENTHS_W-1:0] pct_to_tenths(input logic [PCT_W-1:0] pct);
        logic [TENTHS_W-1:0] ext;
        ext = TENTHS_W'(pct);
        return (ext << 3) + (ext << 1);
    endfunction

endpackage

### design/battery_backup_mode_controller.sv
// battery backup mode controller: charge mode, offload permission, supply decision
// depends on bbmc_pkg
`timescale 1ns / 1ps

// channel | direction | handshake           | word
// in      | into      | in_valid / in_stall   | operation, now_seconds, charge_tenths, ...
// out     | out of    | out_valid / out_stall | charge_mode, offload_allowed, wanted_supply
// cfg     | into      | psel/penable/pwrite   | 8 registers at byte address 4*i
//
// one word per cycle sustained while out_stall is low; each word passes the input register, then the result register
// the mode/charge/permit state loop closes through one set of state registers, which sets that rate
// reset brings config registers to their defaults and clears mode and charge state
// a stalled result holds in the result register; the input register still fills,
// and in_stall rises only when both stages are full and out_stall is high

module battery_backup_mode_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [bbmc_pkg::TIME_BITS-1:0]       now_seconds,
    input  logic [bbmc_pkg::CHARGE_W-1:0]        charge_tenths,
    input  logic                                 direct_state_valid,
    input  logic [bbmc_pkg::DSTATE_W-1:0]        direct_state,
    input  logic                                 charging_flag,
    input  logic                                 grid_offline,
    input  logic                                 manual_mode,
    input  logic                                 control_present,
    input  logic [bbmc_pkg::TIME_BITS-1:0]       last_on_seconds,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bbmc_pkg::MODE_W-1:0]          charge_mode,
    output logic                                 offload_allowed,
    output logic [bbmc_pkg::WANT_W-1:0]          wanted_supply,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bbmc_pkg::ADDR_W-1:0]          paddr,
    input  logic [bbmc_pkg::DATA_W-1:0]          pwdata,
    output logic [bbmc_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    // config registers
    logic [bbmc_pkg::PCT_W-1:0]     backup_low_reg;
    logic [bbmc_pkg::PCT_W-1:0]     backup_high_reg;
    logic [bbmc_pkg::TIME_BITS-1:0] min_grid_reg;
    logic [bbmc_pkg::WATTS_W-1:0]   offload_lim_reg;
    logic [bbmc_pkg::PCT_W-1:0]     offload_low_reg;
    logic [bbmc_pkg::PCT_W-1:0]     offload_high_reg;
    logic [bbmc_pkg::POLICY_W-1:0]  policy_reg;
    logic [bbmc_pkg::TIME_BITS-1:0] cooldown_reg;

    logic                           cfg_wr;
    logic [bbmc_pkg::REG_IDX_W-1:0] cfg_idx;

    // pipeline registers
    logic                           s1_valid_reg;
    bbmc_pkg::item_t                s1_item_reg;
    logic                           s1_move;
    logic                           in_take;

    logic                           out_valid_reg;
    logic [bbmc_pkg::MODE_W-1:0]    out_mode_reg;
    logic                           out_offload_reg;
    logic [bbmc_pkg::WANT_W-1:0]    out_want_reg;

    // controller state
    logic [bbmc_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic [bbmc_pkg::CHARGE_W-1:0]  charge_reg, charge_next;
    logic                           known_reg, known_next;
    logic                           permit_reg, permit_next;
    logic [bbmc_pkg::TIME_BITS-1:0] switch_time_reg, switch_time_next;

    logic [bbmc_pkg::WANT_W-1:0]    want;
    logic                           offload_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[bbmc_pkg::ADDR_W-1:2];

    // config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backup_low_reg   <= bbmc_pkg::RST_BACKUP_LOW;
            backup_high_reg  <= bbmc_pkg::RST_BACKUP_HIGH;
            min_grid_reg     <= bbmc_pkg::RST_MIN_GRID;
            offload_lim_reg  <= bbmc_pkg::RST_OFFLOAD_LIM;
            offload_low_reg  <= bbmc_pkg::RST_OFFLOAD_LOW;
            offload_high_reg <= bbmc_pkg::RST_OFFLOAD_HIGH;
            policy_reg       <= bbmc_pkg::RST_POLICY;
            cooldown_reg     <= bbmc_pkg::RST_COOLDOWN;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                bbmc_pkg::REG_BACKUP_LOW:   backup_low_reg   <= pwdata[bbmc_pkg::PCT_W-1:0];
                bbmc_pkg::REG_BACKUP_HIGH:  backup_high_reg  <= pwdata[bbmc_pkg::PCT_W-1:0];
                bbmc_pkg::REG_MIN_GRID:     min_grid_reg     <= pwdata[bbmc_pkg::TIME_BITS-1:0];
                bbmc_pkg::REG_OFFLOAD_LIM:  offload_lim_reg  <= pwdata[bbmc_pkg::WATTS_W-1:0];
                bbmc_pkg::REG_OFFLOAD_LOW:  offload_low_reg  <= pwdata[bbmc_pkg::PCT_W-1:0];
                bbmc_pkg::REG_OFFLOAD_HIGH: offload_high_reg <= pwdata[bbmc_pkg::PCT_W-1:0];
                bbmc_pkg::REG_POLICY:       policy_reg       <= pwdata[bbmc_pkg::POLICY_W-1:0];
                bbmc_pkg::REG_COOLDOWN:     cooldown_reg     <= pwdata[bbmc_pkg::TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // config read
    always_comb
    begin
        case (cfg_idx)
            bbmc_pkg::REG_BACKUP_LOW:   prdata = bbmc_pkg::DATA_W'(backup_low_reg);
            bbmc_pkg::REG_BACKUP_HIGH:  prdata = bbmc_pkg::DATA_W'(backup_high_reg);
            bbmc_pkg::REG_MIN_GRID:     prdata = bbmc_pkg::DATA_W'(min_grid_reg);
            bbmc_pkg::REG_OFFLOAD_LIM:  prdata = bbmc_pkg::DATA_W'(offload_lim_reg);
            bbmc_pkg::REG_OFFLOAD_LOW:  prdata = bbmc_pkg::DATA_W'(offload_low_reg);
            bbmc_pkg::REG_OFFLOAD_HIGH: prdata = bbmc_pkg::DATA_W'(offload_high_reg);
            bbmc_pkg::REG_POLICY:       prdata = bbmc_pkg::DATA_W'(policy_reg);
            bbmc_pkg::REG_COOLDOWN:     prdata = bbmc_pkg::DATA_W'(cooldown_reg);
            default:                    prdata = '0;
        endcase
    end

    // handshake: input stage moves whenever the result register is free or draining
    assign s1_move  = ~out_valid_reg | ~out_stall;
    assign in_stall = s1_valid_reg & ~s1_move;
    assign in_take  = in_valid & ~in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_move | ~s1_valid_reg)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.operation          <= operation;
            s1_item_reg.now_seconds        <= now_seconds;
            s1_item_reg.charge_tenths      <= charge_tenths;
            s1_item_reg.direct_state_valid <= direct_state_valid;
            s1_item_reg.direct_state       <= direct_state;
            s1_item_reg.charging_flag      <= charging_flag;
            s1_item_reg.grid_offline       <= grid_offline;
            s1_item_reg.manual_mode        <= manual_mode;
            s1_item_reg.control_present    <= control_present;
            s1_item_reg.last_on_seconds    <= last_on_seconds;
        end
    end

    // sample update: backup entry/exit, mode tracking, offload hysteresis
    always_comb
    begin
        logic [bbmc_pkg::TENTHS_W-1:0]  charge_ext;
        logic [bbmc_pkg::TIME_BITS-1:0] since_switch;
        mode_next        = mode_reg;
        charge_next      = charge_reg;
        known_next       = known_reg;
        permit_next      = permit_reg;
        switch_time_next = switch_time_reg;
        charge_ext       = bbmc_pkg::TENTHS_W'(s1_item_reg.charge_tenths);
        since_switch     = s1_item_reg.now_seconds - switch_time_reg;

        if (s1_item_reg.operation == bbmc_pkg::OP_SAMPLE)
        begin
            charge_next = s1_item_reg.charge_tenths;
            known_next  = 1'b1;

            if (charge_ext < bbmc_pkg::pct_to_tenths(backup_low_reg))
            begin
                mode_next = bbmc_pkg::MODE_BACKUP;
            end

            if ((mode_next == bbmc_pkg::MODE_BACKUP) &&
                (charge_ext > bbmc_pkg::pct_to_tenths(backup_high_reg)) &&
                (since_switch > min_grid_reg))
            begin
                mode_next        = bbmc_pkg::MODE_FLOAT;
                switch_time_next = s1_item_reg.now_seconds;
            end

            if (mode_next != bbmc_pkg::MODE_BACKUP)
            begin
                if (s1_item_reg.direct_state_valid)
                begin
                    if (s1_item_reg.direct_state == bbmc_pkg::DSTATE_CHARGING)
                        mode_next = bbmc_pkg::MODE_CHARGING;
                    else if (s1_item_reg.direct_state == bbmc_pkg::DSTATE_DISCHARGING)
                        mode_next = bbmc_pkg::MODE_DISCHARGING;
                    else
                        mode_next = bbmc_pkg::MODE_FLOAT;
                end
                else
                begin
                    // guess from the charging flag, then from the charge trend
                    if ((mode_next != bbmc_pkg::MODE_CHARGING) && s1_item_reg.charging_flag)
                        mode_next = bbmc_pkg::MODE_CHARGING;
                    else if ((mode_next == bbmc_pkg::MODE_CHARGING) &&
                             !s1_item_reg.charging_flag)
                        mode_next = bbmc_pkg::MODE_FLOAT;
                    else if (s1_item_reg.charge_tenths < charge_reg)
                        mode_next = bbmc_pkg::MODE_DISCHARGING;
                end
            end

            if (offload_lim_reg != '0)
            begin
                if (charge_ext >= bbmc_pkg::pct_to_tenths(offload_high_reg))
                    permit_next = 1'b1;
                if (charge_ext < bbmc_pkg::pct_to_tenths(offload_low_reg))
                    permit_next = 1'b0;
            end
        end
    end

    // supply decision on the updated state
    always_comb
    begin
        logic                           backup;
        logic [bbmc_pkg::TIME_BITS-1:0] since_on;
        backup   = (mode_next == bbmc_pkg::MODE_BACKUP);
        since_on = s1_item_reg.now_seconds - s1_item_reg.last_on_seconds;

        if (!s1_item_reg.control_present)
            want = bbmc_pkg::WANT_UNCHANGED;
        else if (!known_next)
            want = bbmc_pkg::WANT_UNCHANGED;
        else if (s1_item_reg.manual_mode && !backup)
            want = bbmc_pkg::WANT_UNCHANGED;
        else if (s1_item_reg.grid_offline && !backup)
            want = bbmc_pkg::WANT_BATTERY;
        else if (policy_reg == bbmc_pkg::POLICY_GRID)
            want = bbmc_pkg::WANT_GRID;
        else if (backup)
            want = bbmc_pkg::WANT_GRID;
        else if (policy_reg == bbmc_pkg::POLICY_BATTERY)
            want = bbmc_pkg::WANT_BATTERY;
        else if ((policy_reg == bbmc_pkg::POLICY_OFFLOAD) && (since_on > cooldown_reg))
            want = bbmc_pkg::WANT_OFFLOAD;
        else
            want = bbmc_pkg::WANT_UNCHANGED;
    end

    assign offload_out = (offload_lim_reg != '0) & permit_next;

    // state registers, updated as a word leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= bbmc_pkg::MODE_FLOAT;
            charge_reg      <= '0;
            known_reg       <= 1'b0;
            permit_reg      <= 1'b0;
            switch_time_reg <= '0;
        end
        else if (s1_valid_reg & s1_move)
        begin
            mode_reg        <= mode_next;
            charge_reg      <= charge_next;
            known_reg       <= known_next;
            permit_reg      <= permit_next;
            switch_time_reg <= switch_time_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg & s1_move)
        begin
            out_mode_reg    <= mode_next;
            out_offload_reg <= offload_out;
            out_want_reg    <= want;
        end
    end

    assign out_valid       = out_valid_reg;
    assign charge_mode     = out_mode_reg;
    assign offload_allowed = out_offload_reg;
    assign wanted_supply   = out_want_reg;

endmodule

### design/bbmc_checker.sv
// port-level checks for the battery backup mode controller, bound to the top level
// depends on bbmc_pkg and battery_backup_mode_controller_defines.svh
`timescale 1ns / 1ps
`include "battery_backup_mode_controller_defines.svh"

module bbmc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [bbmc_pkg::MODE_W-1:0]     charge_mode,
    input logic                            offload_allowed,
    input logic [bbmc_pkg::WANT_W-1:0]     wanted_supply
);

    // a stalled result word holds
    `BBMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(charge_mode) && $stable(offload_allowed)
            && $stable(wanted_supply),
        "stalled result word changed")

    // in backup the decision is grid or nothing
    `BBMC_ASSERT_NOW(a_backup_want, out_valid && (charge_mode == bbmc_pkg::MODE_BACKUP),
        (wanted_supply == bbmc_pkg::WANT_GRID) || (wanted_supply == bbmc_pkg::WANT_UNCHANGED),
        "backup mode gave battery or offload")

    // offload is never wanted while in backup
    `BBMC_ASSERT_NOW(a_offload_mode, out_valid && (wanted_supply == bbmc_pkg::WANT_OFFLOAD),
        charge_mode != bbmc_pkg::MODE_BACKUP, "offload wanted in backup mode")

    // input side only stalls while a result word is held back
    `BBMC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled with result side free")

endmodule

bind battery_backup_mode_controller bbmc_checker u_bbmc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .charge_mode     (charge_mode),
    .offload_allowed (offload_allowed),
    .wanted_supply   (wanted_supply)
);
